// File: src/slbm_pkg.sv
// ----------------------------------------------------------------------------
// slbm_pkg: shared types and constants
// Access codes, region codes, register indexes and the bank state record
// used by the serial-loaded bank mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slbm_pkg;

  // access codes
  localparam logic [2:0] OP_CPU_RD   = 3'd0;
  localparam logic [2:0] OP_CPU_WR   = 3'd1;
  localparam logic [2:0] OP_PPU_RD   = 3'd2;
  localparam logic [2:0] OP_PPU_WR   = 3'd3;
  localparam logic [2:0] OP_SOFT_RST = 3'd4;

  // result regions
  localparam logic [1:0] REGION_NONE    = 2'd0;
  localparam logic [1:0] REGION_PRG_ROM = 2'd1;
  localparam logic [1:0] REGION_PRG_RAM = 2'd2;
  localparam logic [1:0] REGION_CHR     = 2'd3;

  // configuration register indexes
  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_CHR_BANK_COUNT = 1'b1;

  // serial commit targets, address bits 14:13
  localparam logic [1:0] TGT_CONTROL  = 2'd0;
  localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
  localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
  localparam logic [1:0] TGT_PRG      = 2'd3;

  localparam logic [2:0] SHIFT_LEN      = 3'd5;
  localparam logic [4:0] CONTROL_RST    = 5'h1C;
  localparam logic [1:0] MIRROR_RST     = 2'd3;
  localparam logic [7:0] PRG_COUNT_RST  = 8'd16;
  localparam logic [7:0] CHR_COUNT_RST  = 8'd0;

  localparam int unsigned MAPPED_W = 22;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
  } slbm_acc_t;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] chr_wide;
    logic [7:0] prg_low;
    logic [7:0] prg_high;
    logic [2:0] prg_wide;
  } slbm_banks_t;

  typedef struct packed {
    logic                hit;
    logic [1:0]          region;
    logic [MAPPED_W-1:0] mapped;
  } slbm_res_t;

endpackage

// File: src/slbm_loader.sv
// ----------------------------------------------------------------------------
// slbm_loader: serial port and bank registers
// Shifts CPU write bits into the 5-bit loader, commits the fifth bit to
// the control or bank registers, and handles soft reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slbm_loader (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  slbm_pkg::slbm_acc_t  acc,
  input  logic [7:0]           prg_bank_count,
  output slbm_pkg::slbm_banks_t banks,
  output logic [1:0]           mirror_nxt
);

  slbm_pkg::slbm_banks_t banks_r, banks_nxt;
  logic [4:0] sh_val_r, sh_val_nxt;
  logic [2:0] sh_cnt_r, sh_cnt_nxt;
  logic [1:0] mirror_r;
  logic [4:0] shifted;
  logic [7:0] prg_last;

  assign shifted  = {acc.data[0], sh_val_r[4:1]};
  assign prg_last = prg_bank_count - 8'd1;

  always_comb begin
    banks_nxt  = banks_r;
    sh_val_nxt = sh_val_r;
    sh_cnt_nxt = sh_cnt_r;
    mirror_nxt = mirror_r;
    if (upd) begin
      unique case (acc.op)
        slbm_pkg::OP_CPU_WR: begin
          if (acc.addr[15]) begin
            if (acc.data[7]) begin
              sh_val_nxt = '0;
              sh_cnt_nxt = '0;
              banks_nxt.control = banks_r.control | 5'h0C;
            end else if (sh_cnt_r == slbm_pkg::SHIFT_LEN - 3'd1) begin
              sh_val_nxt = '0;
              sh_cnt_nxt = '0;
              case (acc.addr[14:13])
                slbm_pkg::TGT_CONTROL: begin
                  banks_nxt.control = shifted;
                  mirror_nxt        = shifted[1:0];
                end
                slbm_pkg::TGT_CHR_LOW: begin
                  if (banks_r.control[4]) begin
                    banks_nxt.chr_low = shifted;
                  end else begin
                    banks_nxt.chr_wide = {shifted[4:1], 1'b0};
                  end
                end
                slbm_pkg::TGT_CHR_HIGH: begin
                  if (banks_r.control[4]) begin
                    banks_nxt.chr_high = shifted;
                  end
                end
                default: begin
                  // PRG mode from control bits 3:2
                  if (!banks_r.control[3]) begin
                    banks_nxt.prg_wide = shifted[3:1];
                  end else if (!banks_r.control[2]) begin
                    banks_nxt.prg_low  = '0;
                    banks_nxt.prg_high = {4'd0, shifted[3:0]};
                  end else begin
                    banks_nxt.prg_low  = {4'd0, shifted[3:0]};
                    banks_nxt.prg_high = prg_last;
                  end
                end
              endcase
            end else begin
              sh_val_nxt = shifted;
              sh_cnt_nxt = sh_cnt_r + 3'd1;
            end
          end
        end
        slbm_pkg::OP_SOFT_RST: begin
          banks_nxt          = '0;
          banks_nxt.control  = slbm_pkg::CONTROL_RST;
          banks_nxt.prg_high = prg_last;
          sh_val_nxt         = '0;
          sh_cnt_nxt         = '0;
          mirror_nxt         = slbm_pkg::MIRROR_RST;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      banks_r  <= '{control:  slbm_pkg::CONTROL_RST,
                    chr_low:  5'd0,
                    chr_high: 5'd0,
                    chr_wide: 5'd0,
                    prg_low:  8'd0,
                    prg_high: slbm_pkg::PRG_COUNT_RST - 8'd1,
                    prg_wide: 3'd0};
      sh_val_r <= '0;
      sh_cnt_r <= '0;
      mirror_r <= slbm_pkg::MIRROR_RST;
    end else begin
      banks_r  <= banks_nxt;
      sh_val_r <= sh_val_nxt;
      sh_cnt_r <= sh_cnt_nxt;
      mirror_r <= mirror_nxt;
    end
  end

  assign banks = banks_r;

endmodule

// File: src/slbm_xlate.sv
// ----------------------------------------------------------------------------
// slbm_xlate: address translation
// Claims an access and maps it to a PRG ROM, PRG RAM or CHR offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slbm_xlate (
  input  slbm_pkg::slbm_acc_t   acc,
  input  slbm_pkg::slbm_banks_t banks,
  input  logic [7:0]            chr_bank_count,
  output slbm_pkg::slbm_res_t   res
);

  logic [21:0] prg_addr;
  logic [21:0] chr_addr;
  logic        chr_ram;

  assign chr_ram = (chr_bank_count == 8'd0);

  // only used for addresses at 0x8000 and above, so bit 14 picks the half
  always_comb begin
    if (banks.control[3]) begin
      prg_addr = acc.addr[14] ? {banks.prg_high, acc.addr[13:0]}
                              : {banks.prg_low,  acc.addr[13:0]};
    end else begin
      prg_addr = {4'd0, banks.prg_wide, acc.addr[14:0]};
    end
  end

  always_comb begin
    if (chr_ram) begin
      chr_addr = {9'd0, acc.addr[12:0]};
    end else if (banks.control[4]) begin
      chr_addr = acc.addr[12] ? {5'd0, banks.chr_high, acc.addr[11:0]}
                              : {5'd0, banks.chr_low,  acc.addr[11:0]};
    end else begin
      chr_addr = {5'd0, banks.chr_wide, 12'd0} + {9'd0, acc.addr[12:0]};
    end
  end

  always_comb begin
    res = '0;
    unique case (acc.op)
      slbm_pkg::OP_CPU_RD, slbm_pkg::OP_CPU_WR: begin
        if (acc.addr[15:13] == 3'b011) begin
          res.hit    = 1'b1;
          res.region = slbm_pkg::REGION_PRG_RAM;
          res.mapped = {9'd0, acc.addr[12:0]};
        end else if (acc.addr[15] && acc.op == slbm_pkg::OP_CPU_RD) begin
          res.hit    = 1'b1;
          res.region = slbm_pkg::REGION_PRG_ROM;
          res.mapped = prg_addr;
        end
      end
      slbm_pkg::OP_PPU_RD, slbm_pkg::OP_PPU_WR: begin
        if (acc.addr[15:13] == 3'b000 && (acc.op == slbm_pkg::OP_PPU_RD || chr_ram)) begin
          res.hit    = 1'b1;
          res.region = slbm_pkg::REGION_CHR;
          res.mapped = chr_addr;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/serial_loaded_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_core: serially loaded cartridge bank mapper
// Takes one bus request per cycle unless stalled (CPU read/write, PPU
// read/write or soft reset) and returns exactly one result per request:
// whether the mapper claims it, the region, the translated address and the
// mirroring mode after the request. CPU writes at 0x8000 and above load the
// 5-bit serial register; the fifth bit commits to control, CHR or PRG bank
// registers. A request is registered, passes once through the loader and
// translation logic and lands in the result register: one request per
// cycle sustained while out_ready allows, with the serial/bank update
// completing in that single pass so the next request sees it. The result
// register stalls on out_ready without stopping intake while it has room.
// The user writes configuration (prg_bank_count, chr_bank_count) with
// cfg_we only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [1:0]  out_region,
  output logic [21:0] out_xlat_addr,
  output logic [1:0]  out_mirror_mode,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  // configuration registers
  logic [7:0] prg_count_r;
  logic [7:0] chr_count_r;

  // input stage
  logic                s1_valid_r;
  slbm_pkg::slbm_acc_t s1_acc_r;

  // result stage
  logic       out_valid_r;
  logic       out_hit_r;
  logic [1:0] out_region_r;
  logic [21:0] out_mapped_r;
  logic [1:0] out_mirror_r;

  slbm_pkg::slbm_banks_t banks;
  slbm_pkg::slbm_res_t   res;
  logic [1:0]            mirror_nxt;
  logic                  adv;
  logic                  in_take;

  // stage 1 moves on when the result register is empty or being drained
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r <= slbm_pkg::PRG_COUNT_RST;
      chr_count_r <= slbm_pkg::CHR_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slbm_pkg::CFG_PRG_BANK_COUNT: prg_count_r <= cfg_wdata;
        slbm_pkg::CFG_CHR_BANK_COUNT: chr_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_acc_r.op   <= in_op;
      s1_acc_r.addr <= in_addr;
      s1_acc_r.data <= in_data;
    end
  end

  // bank state advances only as the request moves into the result register
  slbm_loader u_loader (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd            (adv),
    .acc            (s1_acc_r),
    .prg_bank_count (prg_count_r),
    .banks          (banks),
    .mirror_nxt     (mirror_nxt)
  );

  // translation uses bank state from before this request
  slbm_xlate u_xlate (
    .acc            (s1_acc_r),
    .banks          (banks),
    .chr_bank_count (chr_count_r),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r    <= res.hit;
      out_region_r <= res.region;
      out_mapped_r <= res.mapped;
      out_mirror_r <= mirror_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_region      = out_region_r;
  assign out_xlat_addr   = out_mapped_r;
  assign out_mirror_mode = out_mirror_r;

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for serial_loaded_bank_mapper_core
// Drives bus requests through the valid/ready request channel, keeps its own
// model of the serial loader and bank registers, and compares every result
// (claim, region, translated address, mirroring) in order. Covers the
// directed address extremes, all PRG/CHR banking modes across bank-count
// settings, output back-pressure and long randomised serial load traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // PRG banking modes, control bits 3:2 (0 and 1 both switch 32KB)
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;
  // highest encodable request code; codes above soft reset do nothing
  localparam logic [2:0] OP_CODE_MAX        = 3'd7;

  localparam int HOLD_CYCLES   = 160;
  localparam int SETTLE_CYCLES = 6;
  localparam int TIMEOUT_NS    = 2_000_000;

  // one expected or observed result
  typedef struct packed {
    logic        hit;
    logic [1:0]  region;
    logic [21:0] mapped;
    logic [1:0]  mirror;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic [1:0]  out_region;
  logic [21:0] out_xlat_addr;
  logic [1:0]  out_mirror_mode;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;

  // idling switches and the receiver hold-off request
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  bit hold_request = 1'b0;

  int mismatch_count = 0;
  int accesses_sent  = 0;

  bus_result_t pending_results[$];

  // mapper model state
  slbm_pkg::slbm_banks_t banks;
  logic [4:0]  shift_bits;
  logic [2:0]  shift_len;
  logic [1:0]  mirror_q;
  logic [7:0]  prg_count;
  logic [7:0]  chr_count;

  serial_loaded_bank_mapper_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_addr         (in_addr),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_region      (out_region),
    .out_xlat_addr   (out_xlat_addr),
    .out_mirror_mode (out_mirror_mode),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the mapper
  // --------------------------------------------------------------------------

  // soft reset and power-up state; the bank counts are left alone
  function automatic void clear_mapper();
    banks.control  = slbm_pkg::CONTROL_RST;
    banks.chr_low  = '0;
    banks.chr_high = '0;
    banks.chr_wide = '0;
    banks.prg_low  = '0;
    banks.prg_high = prg_count - 8'd1;   // wraps to 255 for a zero count
    banks.prg_wide = '0;
    shift_bits     = '0;
    shift_len      = '0;
    mirror_q       = slbm_pkg::MIRROR_RST;
  endfunction

  // PRG ROM offset for a CPU read at 0x8000 and above
  function automatic logic [21:0] prg_rom_addr(input logic [15:0] addr);
    int unsigned off;
    if (banks.control[3]) begin
      // 16KB banking: low window below 0xC000, high window above
      if (addr <= 16'hBFFF)
        off = banks.prg_low * 32'h4000 + addr[13:0];
      else
        off = banks.prg_high * 32'h4000 + addr[13:0];
    end else begin
      off = banks.prg_wide * 32'h8000 + addr[14:0];
    end
    return off[21:0];
  endfunction

  // CHR offset for a PPU access below 0x2000
  function automatic logic [21:0] chr_addr(input logic [15:0] addr);
    int unsigned off;
    if (chr_count == 8'd0)
      off = {16'd0, addr};                // CHR RAM, untranslated
    else if (banks.control[4]) begin
      if (addr <= 16'h0FFF)
        off = banks.chr_low * 32'h1000 + addr[11:0];
      else
        off = banks.chr_high * 32'h1000 + addr[11:0];
    end else begin
      off = banks.chr_wide * 32'h1000 + addr;
    end
    return off[21:0];
  endfunction

  // Result of one request, updating the model state on the way
  function automatic bus_result_t predict_access(input logic [2:0] op,
                                                 input logic [15:0] addr,
                                                 input logic [7:0] data);
    bus_result_t r;
    r = '0;
    case (op)
      slbm_pkg::OP_CPU_RD, slbm_pkg::OP_CPU_WR: begin
        if (addr >= 16'h6000 && addr <= 16'h7FFF) begin
          r.hit    = 1'b1;
          r.region = slbm_pkg::REGION_PRG_RAM;
          r.mapped = {9'd0, addr[12:0]};
        end else if (addr[15]) begin
          if (op == slbm_pkg::OP_CPU_RD) begin
            r.hit    = 1'b1;
            r.region = slbm_pkg::REGION_PRG_ROM;
            r.mapped = prg_rom_addr(addr);
          end else if (data[7]) begin
            // loader reset: forces fix-last PRG mode
            shift_bits    = '0;
            shift_len     = '0;
            banks.control = banks.control | 5'h0C;
          end else begin
            // LSB-first shift; the fifth bit commits, target from addr 14:13
            shift_bits = {data[0], shift_bits[4:1]};
            shift_len  = shift_len + 3'd1;
            if (shift_len >= slbm_pkg::SHIFT_LEN) begin
              case (addr[14:13])
                slbm_pkg::TGT_CONTROL: begin
                  banks.control = shift_bits;
                  mirror_q      = shift_bits[1:0];
                end
                slbm_pkg::TGT_CHR_LOW: begin
                  if (banks.control[4])
                    banks.chr_low = shift_bits;
                  else
                    banks.chr_wide = shift_bits & 5'h1E;
                end
                slbm_pkg::TGT_CHR_HIGH: begin
                  if (banks.control[4])
                    banks.chr_high = shift_bits;
                end
                slbm_pkg::TGT_PRG: begin
                  case (banks.control[3:2])
                    PRG_MODE_FIX_FIRST: begin
                      banks.prg_low  = '0;
                      banks.prg_high = {4'd0, shift_bits[3:0]};
                    end
                    PRG_MODE_FIX_LAST: begin
                      banks.prg_low  = {4'd0, shift_bits[3:0]};
                      banks.prg_high = prg_count - 8'd1;
                    end
                    default: banks.prg_wide = shift_bits[3:1];
                  endcase
                end
              endcase
              shift_bits = '0;
              shift_len  = '0;
            end
          end
        end
      end
      slbm_pkg::OP_PPU_RD, slbm_pkg::OP_PPU_WR: begin
        // PPU writes are only claimed with CHR RAM fitted
        if (addr < 16'h2000 && (op == slbm_pkg::OP_PPU_RD || chr_count == 8'd0)) begin
          r.hit    = 1'b1;
          r.region = slbm_pkg::REGION_CHR;
          r.mapped = chr_addr(addr);
        end
      end
      slbm_pkg::OP_SOFT_RST: clear_mapper();
      default: ;
    endcase
    r.mirror = mirror_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // gap before a request: mostly none or short, now and then long
  function automatic int tx_gap();
    int pick;
    if (!tx_idle)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65)
      return 0;
    if (pick < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Entered and left at a falling edge. Valid is left high after acceptance
  // so the next call can follow back to back; anything else lowers it first.
  task automatic send_access(input logic [2:0] op, input logic [15:0] addr,
                             input logic [7:0] data);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_op    = op;
    in_addr  = addr;
    in_data  = data;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_access(op, addr, data));
    accesses_sent++;
    @(negedge clk);
  endtask

  // Pause requests until every result is back, then let the pipe settle
  task automatic wait_drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Bank counts are only changed with the block idle
  task automatic set_register(input logic idx, input logic [7:0] value);
    wait_drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == slbm_pkg::CFG_PRG_BANK_COUNT)
      prg_count = value;
    else
      chr_count = value;
  endtask

  // One random request, biased towards the mapped windows; soft resets
  // and undefined codes are kept rare so serial loads get somewhere.
  task automatic random_access();
    int          pick;
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    pick = $urandom_range(0, 99);
    addr = 16'($urandom);
    data = 8'($urandom);
    if (pick < 30) begin
      op       = slbm_pkg::OP_CPU_RD;
      addr[15] = 1'b1;
    end else if (pick < 42) begin
      op          = pick[0] ? slbm_pkg::OP_CPU_WR : slbm_pkg::OP_CPU_RD;
      addr[15:13] = 3'b011;
    end else if (pick < 70) begin
      op          = pick[0] ? slbm_pkg::OP_PPU_WR : slbm_pkg::OP_PPU_RD;
      addr[15:13] = 3'b000;
    end else if (pick < 94) begin
      op = 3'($urandom_range(slbm_pkg::OP_CPU_RD, slbm_pkg::OP_PPU_WR));
    end else if (pick < 97) begin
      op = slbm_pkg::OP_SOFT_RST;
    end else begin
      op = 3'($urandom_range(slbm_pkg::OP_SOFT_RST + 3'd1, OP_CODE_MAX));
    end
    send_access(op, addr, data);
  endtask

  // Five serial writes loading value into target. With noise on, other
  // requests are mixed in and a few loads are cut short by a loader reset.
  task automatic load_register(input logic [1:0] target, input logic [4:0] value,
                               input bit noisy);
    logic [15:0] addr;
    logic [7:0]  data;
    for (int i = 0; i < 5; i++) begin
      if (noisy && $urandom_range(0, 99) < 10)
        random_access();
      addr     = 16'($urandom);
      addr[15] = 1'b1;
      data     = 8'($urandom);
      if (noisy && $urandom_range(0, 99) < 3) begin
        data[7] = 1'b1;
        send_access(slbm_pkg::OP_CPU_WR, addr, data);
        return;
      end
      if (i == 4)
        addr[14:13] = target;
      data[7] = 1'b0;
      data[0] = value[i];
      send_access(slbm_pkg::OP_CPU_WR, addr, data);
    end
    if (noisy)
      repeat ($urandom_range(1, 4)) random_access();
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Receiver: random stalls, or held off for a long stretch on request
  initial begin : result_sink
    int run;
    run       = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready    = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        run = 0;
      end else if (!rx_idle) begin
        out_ready = 1'b1;
      end else if (run > 0) begin
        run--;
      end else if (out_ready) begin
        out_ready = 1'b0;
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                         : $urandom_range(10, 50);
      end else begin
        out_ready = 1'b1;
        run       = $urandom_range(0, 12);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    bus_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0h, got %0h", want.hit, out_hit);
          mismatch_count++;
        end
        if (out_region !== want.region) begin
          $error("region: expected %0h, got %0h", want.region, out_region);
          mismatch_count++;
        end
        if (out_xlat_addr !== want.mapped) begin
          $error("xlat_addr: expected %0h, got %0h", want.mapped, out_xlat_addr);
          mismatch_count++;
        end
        if (out_mirror_mode !== want.mirror) begin
          $error("mirror_mode: expected %0h, got %0h", want.mirror, out_mirror_mode);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Address extremes, every request code and the loader reset, at the
  // power-up bank counts
  task automatic test_directed_edges();
    send_access(slbm_pkg::OP_CPU_RD, 16'h0000, 8'h00);   // below PRG RAM, unclaimed
    send_access(slbm_pkg::OP_CPU_RD, 16'h5FFF, 8'h00);
    send_access(slbm_pkg::OP_CPU_RD, 16'h6000, 8'h00);   // PRG RAM window edges
    send_access(slbm_pkg::OP_CPU_WR, 16'h7FFF, 8'hFF);
    send_access(slbm_pkg::OP_CPU_RD, 16'h8000, 8'h00);   // fix-last mode after reset
    send_access(slbm_pkg::OP_CPU_RD, 16'hBFFF, 8'h00);
    send_access(slbm_pkg::OP_CPU_RD, 16'hC000, 8'h00);
    send_access(slbm_pkg::OP_CPU_RD, 16'hFFFF, 8'hFF);
    send_access(slbm_pkg::OP_CPU_WR, 16'h4020, 8'hFF);   // low CPU write, unclaimed
    send_access(slbm_pkg::OP_PPU_RD, 16'h0000, 8'h00);
    send_access(slbm_pkg::OP_PPU_WR, 16'h1FFF, 8'hFF);   // claimed: CHR RAM
    send_access(slbm_pkg::OP_PPU_RD, 16'h2000, 8'h00);   // nametable space, unclaimed
    send_access(slbm_pkg::OP_PPU_WR, 16'hFFFF, 8'h00);
    // control = 4KB CHR, 32KB PRG, vertical mirroring
    load_register(slbm_pkg::TGT_CONTROL, 5'b10010, 1'b0);
    send_access(slbm_pkg::OP_CPU_WR, 16'h8000, 8'h80);   // loader reset
    send_access(slbm_pkg::OP_SOFT_RST + 3'd1, 16'hFFFF, 8'hFF);
    send_access(slbm_pkg::OP_SOFT_RST + 3'd2, 16'h8000, 8'h7F);
    send_access(OP_CODE_MAX, 16'h0000, 8'h80);
    send_access(slbm_pkg::OP_SOFT_RST, 16'h8000, 8'h00);
  endtask

  // Every PRG/CHR banking mode under bank counts at their extremes,
  // including the zero PRG count whose fixed bank wraps to 255
  task automatic test_bank_modes();
    logic [7:0] prg_sel [4];
    logic [7:0] chr_sel [4];
    logic [4:0] ctl;
    prg_sel = '{8'd1, 8'd255, 8'd0, 8'd16};
    chr_sel = '{8'd1, 8'd255, 8'd0, 8'd4};
    for (int c = 0; c < 4; c++) begin
      set_register(slbm_pkg::CFG_PRG_BANK_COUNT, prg_sel[c]);
      set_register(slbm_pkg::CFG_CHR_BANK_COUNT, chr_sel[c]);
      send_access(slbm_pkg::OP_SOFT_RST, 16'h0000, 8'h00);
      send_access(slbm_pkg::OP_CPU_RD, 16'hFFFF, 8'h00);
      send_access(slbm_pkg::OP_CPU_RD, 16'h8000, 8'h00);
      for (int m = 0; m < 4; m++) begin
        ctl      = 5'($urandom);
        ctl[3:2] = 2'(m);
        ctl[4]   = ctl[2];
        load_register(slbm_pkg::TGT_CONTROL, ctl, 1'b0);
        load_register(slbm_pkg::TGT_PRG, 5'($urandom), 1'b0);
        load_register(slbm_pkg::TGT_CHR_LOW, 5'($urandom), 1'b0);
        load_register(slbm_pkg::TGT_CHR_HIGH, 5'($urandom), 1'b0);
        repeat (6) random_access();
      end
    end
  endtask

  // Receiver held off while requests keep coming, so the block fills and
  // stalls intake; then requests pause until everything is back
  task automatic test_backpressure();
    tx_idle      = 1'b0;
    hold_request = 1'b1;
    repeat (40) random_access();
    wait_drain();
    tx_idle = 1'b1;
  endtask

  // Mostly well-formed serial loads with random content, the rest noise,
  // over several bank-count settings; one phase runs without any idling
  task automatic test_random_traffic();
    logic [7:0] prg_sel [6];
    logic [7:0] chr_sel [6];
    int         stop_at;
    prg_sel    = '{8'd16, 8'd8, 8'd1, 8'd255, 8'd0, 8'd0};
    chr_sel    = '{8'd0, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0};
    prg_sel[5] = 8'($urandom_range(1, 255));
    chr_sel[5] = 8'($urandom_range(0, 255));
    for (int ph = 0; ph < 6; ph++) begin
      set_register(slbm_pkg::CFG_PRG_BANK_COUNT, prg_sel[ph]);
      set_register(slbm_pkg::CFG_CHR_BANK_COUNT, chr_sel[ph]);
      tx_idle = (ph != 1);
      rx_idle = (ph != 1);
      if ($urandom_range(0, 1))
        send_access(slbm_pkg::OP_SOFT_RST, 16'($urandom), 8'($urandom));
      stop_at = accesses_sent + 230;
      while (accesses_sent < stop_at) begin
        if ($urandom_range(0, 99) < 70)
          load_register(2'($urandom_range(0, 3)), 5'($urandom), 1'b1);
        else
          random_access();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_op     = slbm_pkg::OP_CPU_RD;
    in_addr   = '0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = slbm_pkg::CFG_PRG_BANK_COUNT;
    cfg_wdata = '0;
    prg_count = slbm_pkg::PRG_COUNT_RST;
    chr_count = slbm_pkg::CHR_COUNT_RST;
    clear_mapper();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_edges();
    test_bank_modes();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Hard stop if results stop arriving
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// File: serial_loaded_bank_mapper_core.f
src/slbm_pkg.sv
src/slbm_loader.sv
src/slbm_xlate.sv
src/serial_loaded_bank_mapper_core.sv
sim/testbench.sv
